// File: hdl/rsq_pkg.sv
// Package: shared widths, request codes, controller state and control structs
`default_nettype none
package rsq_pkg;

    // Field widths of the request and response channels
    localparam int POS_W  = 11;
    localparam int DATA_W = 32;

    // Default number of stored positions
    localparam int DEPTH_DEFAULT = 1024;

    // Request modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic write;    // store value at position
        logic load;     // latch query bounds and threshold, clear best
        logic issue;    // read the current position, advance pointer
        logic publish;  // move best into the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;    // clipped range of the incoming query is empty
        logic last;     // pointer sits on the last position of the range
        logic out_busy; // output register holds a response not yet taken
    } status_t;

endpackage
`default_nettype wire

// File: hdl/rsq_ctrl.sv
// Controller: sequences writes, range scans and response hand-off
`default_nettype none
module rsq_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            mode,
    output logic                 in_ready,
    input  wire rsq_pkg::status_t status,
    output rsq_pkg::cmd_t        cmd
);

    rsq_pkg::state_t state_reg;
    rsq_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            rsq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode == rsq_pkg::MODE_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        // an empty range skips the scan entirely
                        state_next = status.empty ? rsq_pkg::ST_RESULT : rsq_pkg::ST_SCAN;
                    end
                end
            end
            rsq_pkg::ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.last)
                begin
                    state_next = rsq_pkg::ST_DRAIN;
                end
            end
            rsq_pkg::ST_DRAIN:
            begin
                // last read word is compared this cycle
                state_next = rsq_pkg::ST_RESULT;
            end
            rsq_pkg::ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = rsq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/rsq_datapath.sv
// Datapath: value memory, scan pointer, successor compare and output register
`default_nettype none
module rsq_datapath
#(
    parameter int DEPTH = rsq_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rsq_pkg::cmd_t                     cmd,
    output rsq_pkg::status_t                       status,
    input  wire logic        [rsq_pkg::POS_W-1:0]  position,
    input  wire logic signed [rsq_pkg::DATA_W-1:0] value,
    input  wire logic        [rsq_pkg::POS_W-1:0]  range_low,
    input  wire logic        [rsq_pkg::POS_W-1:0]  range_high,
    input  wire logic signed [rsq_pkg::DATA_W-1:0] threshold,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   found,
    output logic signed [rsq_pkg::DATA_W-1:0]      successor
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = ($clog2(DEPTH + 1) > rsq_pkg::POS_W) ?
                            $clog2(DEPTH + 1) : rsq_pkg::POS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // Value store, no reset: the user must write entries before a query covers them; the block does not enforce it
    logic signed [rsq_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [rsq_pkg::DATA_W-1:0] rd_data_reg;
    logic                              rd_vld_reg;

    // Scan state
    logic [CNT_W-1:0]                  cur_reg;
    logic [CNT_W-1:0]                  hi_reg;
    logic signed [rsq_pkg::DATA_W-1:0] thr_reg;
    logic signed [rsq_pkg::DATA_W-1:0] best_reg;
    logic                              hit_reg;

    // Output register
    logic                              out_valid_reg;
    logic                              found_reg;
    logic signed [rsq_pkg::DATA_W-1:0] successor_reg;

    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  lo_clip;
    logic [CNT_W-1:0]  hi_clip;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  cur_m1;
    logic              wr_ok;
    logic              better;

    // Bounds clipping and write address check
    always_comb
    begin
        pos_ext = CNT_W'(position);
        lo_clip = CNT_W'(range_low);
        hi_clip = CNT_W'(range_high);
        if (lo_clip < ONE_C)
        begin
            lo_clip = ONE_C;
        end
        if (hi_clip > DEPTH_C)
        begin
            hi_clip = DEPTH_C;
        end
        wr_ok  = (pos_ext >= ONE_C) && (pos_ext <= DEPTH_C);
        pos_m1 = pos_ext - ONE_C;
        cur_m1 = cur_reg - ONE_C;
    end

    // Candidate beats threshold and the best so far
    assign better = rd_vld_reg && (rd_data_reg > thr_reg) &&
                    (!hit_reg || (rd_data_reg < best_reg));

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
        begin
            mem[pos_m1[ADDR_W-1:0]] <= value;
        end
        rd_data_reg <= mem[cur_m1[ADDR_W-1:0]];
    end

    // Read-valid flag is set in the cycle after each issued read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
        end
    end

    // Scan pointer, bounds and running best
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg <= 1'b0;
        end
        else if (better)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= lo_clip;
            hi_reg  <= hi_clip;
            thr_reg <= threshold;
        end
        else if (cmd.issue)
        begin
            cur_reg <= cur_reg + ONE_C;
        end
        if (better)
        begin
            best_reg <= rd_data_reg;
        end
    end

    // Output register, freed when the receiver takes the response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            found_reg     <= hit_reg;
            successor_reg <= hit_reg ? best_reg : '0;
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.empty    = (lo_clip > hi_clip);
        status.last     = (cur_reg == hi_reg);
        status.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign successor = successor_reg;

endmodule
`default_nettype wire

// File: hdl/range_successor_query_core.sv
// Range successor query: top level joining controller and datapath
//
// Request channel (in_valid/in_ready): mode 0 writes value at 1-based
// position (positions 0 or above DEPTH are dropped); mode 1 asks for the
// smallest stored value strictly above threshold among positions
// range_low..range_high, bounds clipped to 1..DEPTH.
// Response channel (out_valid/out_ready): one response per query, found
// plus successor (zero when nothing qualifies). Writes give no response.
// Throughput: writes are accepted back to back while no query is in
// progress. A query holds in_ready low while it scans its clipped
// positions, drains the last read and waits to publish; an empty range
// skips the scan and drain. The response then appears in the output
// register. The scan is set by the single memory read port, one
// position per cycle.
// Stall: a finished response waits in the output register; writes are
// still accepted, and a following query scans but holds its result
// until the register is taken.
// Reset clears control state and the output valid; stored values are
// undefined until written.
`default_nettype none
module range_successor_query_core
#(
    parameter int DEPTH = rsq_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic        [rsq_pkg::POS_W-1:0]  position,
    input  wire logic signed [rsq_pkg::DATA_W-1:0] value,
    input  wire logic        [rsq_pkg::POS_W-1:0]  range_low,
    input  wire logic        [rsq_pkg::POS_W-1:0]  range_high,
    input  wire logic signed [rsq_pkg::DATA_W-1:0] threshold,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   found,
    output logic signed [rsq_pkg::DATA_W-1:0]      successor
);

    rsq_pkg::cmd_t    cmd;
    rsq_pkg::status_t status;

    // Controller
    rsq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    rsq_datapath #(.DEPTH(DEPTH)) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .position   (position),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .threshold  (threshold),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .successor  (successor)
    );

endmodule
`default_nettype wire

// File: hdl/rsq_checker.sv
// Checker on the top-level ports, bound to the core
`default_nettype none
module rsq_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              mode,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic                              found,
    input wire logic signed [rsq_pkg::DATA_W-1:0] successor
);

    // A stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(successor))
        else $error("response changed while stalled");

    // Not-found responses carry a zero successor
    a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> successor == '0)
        else $error("not-found response with nonzero successor");

    // An accepted query keeps the block busy the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode == rsq_pkg::MODE_QUERY |=> !in_ready)
        else $error("request accepted right after a query");

    // A write never produces a response
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode == rsq_pkg::MODE_WRITE && !out_valid |=> !out_valid)
        else $error("response appeared after a write");

endmodule

bind range_successor_query_core rsq_checker u_rsq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .successor (successor)
);
`default_nettype wire

// File: dv/range_successor_query_core_test.sv
// Testbench for range_successor_query_core: random write/query traffic checked against a mirror
`timescale 1ns / 100ps

module range_successor_query_core_test;

    localparam int POS_W            = rsq_pkg::POS_W;
    localparam int DATA_W           = rsq_pkg::DATA_W;
    localparam int LAST_POS         = rsq_pkg::DEPTH_DEFAULT;
    localparam int POS_TOP          = (1 << POS_W) - 1;
    localparam int LONG_HOLD_CYCLES = 2500;
    localparam int EARLY_ITEMS      = 240;
    localparam int LATE_ITEMS       = 290;
    localparam int HOLD_AT_ITEM     = 120;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic                     mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         range_low;
        logic [POS_W-1:0]         range_high;
        logic signed [DATA_W-1:0] threshold;
    } request_t;

    typedef struct {
        logic                     found;
        logic signed [DATA_W-1:0] successor;
    } answer_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_EVERY_FOURTH
    } ready_pattern_t;

    // Mirror of the stored array plus the answers still owed by the block
    class successor_scoreboard;
        logic signed [DATA_W-1:0] stored_mem [1:LAST_POS];
        answer_t                  pending_answers [$];
        int                       errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        // smallest stored value strictly above thr inside the clipped range
        function answer_t smallest_above(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                         logic signed [DATA_W-1:0] thr);
            answer_t a;
            int      from_pos;
            int      to_pos;
            int      p;
            a.found     = 1'b0;
            a.successor = '0;
            from_pos    = (lo < 1) ? 1 : int'(lo);
            to_pos      = (hi > LAST_POS) ? LAST_POS : int'(hi);
            for (p = from_pos; p <= to_pos; p++)
            begin
                if (stored_mem[p] > thr && (!a.found || stored_mem[p] < a.successor))
                begin
                    a.found     = 1'b1;
                    a.successor = stored_mem[p];
                end
            end
            return a;
        endfunction

        function void note_request(request_t r);
            if (r.mode == rsq_pkg::MODE_WRITE)
            begin
                // out-of-range positions are dropped by the block
                if (r.position >= 1 && r.position <= LAST_POS)
                    stored_mem[r.position] = r.value;
            end
            else
                pending_answers = {pending_answers,
                                   smallest_above(r.range_low, r.range_high, r.threshold)};
        endfunction

        task check_response(logic got_found, logic signed [DATA_W-1:0] got_successor);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                report_mismatch("response with no query pending");
                return;
            end
            want = pending_answers.pop_front();
            if (got_found !== want.found)
                report_mismatch($sformatf("found %b, expected %b", got_found, want.found));
            if (got_successor !== want.successor)
                report_mismatch($sformatf("successor %0d, expected %0d",
                                          got_successor, want.successor));
        endtask
    endclass

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     mode       = rsq_pkg::MODE_WRITE;
    logic [POS_W-1:0]         position   = '0;
    logic signed [DATA_W-1:0] value      = '0;
    logic [POS_W-1:0]         range_low  = '0;
    logic [POS_W-1:0]         range_high = '0;
    logic signed [DATA_W-1:0] threshold  = '0;
    logic                     out_ready  = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic                     found;
    logic signed [DATA_W-1:0] successor;

    successor_scoreboard sb;

    // positions written so far; queries only ever cover these
    bit written [1:LAST_POS];
    int written_list [$];
    int next_low       = 1;
    int next_high      = LAST_POS;
    int burst_left     = 0;
    int stall_requests = 0;
    int stall_served   = 0;

    range_successor_query_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .position   (position),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .threshold  (threshold),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .successor  (successor)
    );

    always #5 clk = ~clk;

    // Request driver: bursts of back-to-back requests with random gaps
    task automatic send_request(request_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        mode       <= r.mode;
        position   <= r.position;
        value      <= r.value;
        range_low  <= r.range_low;
        range_high <= r.range_high;
        threshold  <= r.threshold;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic send_write(int pos, logic signed [DATA_W-1:0] val);
        request_t r;
        r.mode       = rsq_pkg::MODE_WRITE;
        r.position   = pos[POS_W-1:0];
        r.value      = val;
        r.range_low  = POS_W'($urandom);
        r.range_high = POS_W'($urandom);
        r.threshold  = $urandom;
        if (pos >= 1 && pos <= LAST_POS && !written[pos])
        begin
            written[pos] = 1'b1;
            written_list = {written_list, pos};
        end
        send_request(r);
    endtask

    task automatic send_query(int lo, int hi, logic signed [DATA_W-1:0] thr);
        request_t r;
        r.mode       = rsq_pkg::MODE_QUERY;
        r.position   = POS_W'($urandom);
        r.value      = $urandom;
        r.range_low  = lo[POS_W-1:0];
        r.range_high = hi[POS_W-1:0];
        r.threshold  = thr;
        send_request(r);
    endtask

    // mix of full-width, near-zero, extreme and tie-prone values
    function automatic logic signed [DATA_W-1:0] random_value();
        int pick;
        int small_val;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom;
        if (pick < 6)
        begin
            small_val = int'($urandom_range(0, 16)) - 8;
            return small_val;
        end
        if (pick < 7)
            return ($urandom_range(0, 1) == 1) ? VALUE_MIN : VALUE_MAX;
        small_val = int'($urandom_range(0, 7)) * 100 - 300;
        return small_val;
    endfunction

    // Query over a run of written positions grown around a random anchor
    task automatic send_random_query(int span_max);
        int                       anchor;
        int                       lo;
        int                       hi;
        int                       want;
        int                       i;
        int                       pick;
        int                       rl;
        int                       rh;
        bit                       down_ok;
        bit                       up_ok;
        logic signed [DATA_W-1:0] probe_val;
        logic signed [DATA_W-1:0] thr;
        anchor = written_list[$urandom_range(0, written_list.size() - 1)];
        lo     = anchor;
        hi     = anchor;
        want   = $urandom_range(0, span_max - 1);
        for (i = 0; i < want; i++)
        begin
            down_ok = (lo > 1) && written[lo - 1];
            up_ok   = (hi < LAST_POS) && written[hi + 1];
            if (down_ok && (!up_ok || $urandom_range(0, 1) == 1))
                lo--;
            else if (up_ok)
                hi++;
        end
        // threshold near a stored value so hits, misses and ties all occur
        probe_val = sb.stored_mem[$urandom_range(lo, hi)];
        pick      = $urandom_range(0, 9);
        if (pick < 2)
            thr = $urandom;
        else if (pick < 4)
            thr = probe_val;
        else if (pick < 6)
            thr = probe_val - 1;
        else if (pick < 7)
            thr = VALUE_MIN;
        else if (pick < 8)
            thr = VALUE_MAX;
        else
            thr = probe_val + (int'($urandom_range(0, 200)) - 100);
        // bounds past either end get clipped by the block
        rl = (lo == 1 && $urandom_range(0, 1) == 1) ? 0 : lo;
        rh = (hi == LAST_POS && $urandom_range(0, 1) == 1)
             ? int'($urandom_range(LAST_POS + 1, POS_TOP)) : hi;
        send_query(rl, rh, thr);
    endtask

    // Query whose clipped range holds no position
    task automatic send_empty_query();
        int lo;
        int hi;
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
        begin
            lo = $urandom_range(1, POS_TOP);
            hi = $urandom_range(0, lo - 1);
        end
        else if (pick == 1)
        begin
            lo = $urandom_range(LAST_POS + 1, POS_TOP);
            hi = $urandom_range(lo, POS_TOP);
        end
        else
        begin
            lo = 0;
            hi = 0;
        end
        send_query(lo, hi, random_value());
    endtask

    task automatic drain_responses();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_answers.size() != 0);
    endtask

    // Random traffic; the first phase grows the written region from both ends,
    // later writes land anywhere
    task automatic run_random_phase(int items, bit filled);
        int done;
        int pick;
        int pos;
        int span;
        done = 0;
        while (done < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // write to a position the block drops
                pos = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(LAST_POS + 1, POS_TOP);
                send_write(pos, random_value());
            end
            else
            begin
                done++;
                if (!filled && done == HOLD_AT_ITEM)
                    stall_requests++;
                if (pick < 48)
                begin
                    if (filled)
                        pos = $urandom_range(1, LAST_POS);
                    else if (next_low <= next_high && $urandom_range(0, 3) < 2)
                        pos = next_low++;
                    else if (next_low <= next_high && $urandom_range(0, 1) == 1)
                        pos = next_high--;
                    else
                        pos = written_list[$urandom_range(0, written_list.size() - 1)];
                    send_write(pos, random_value());
                end
                else if (pick < 92)
                begin
                    span = $urandom_range(0, 99);
                    if (!filled)
                        span = 64;
                    else if (span < 90)
                        span = 32;
                    else if (span < 98)
                        span = 256;
                    else
                        span = LAST_POS;
                    send_random_query(span);
                end
                else
                    send_empty_query();
            end
        end
    endtask

    // Response side: stall patterns that change every so often, plus a long hold-off
    initial
    begin
        ready_pattern_t pattern;
        int             pattern_left;
        int             hold_left;
        pattern      = READY_ALWAYS;
        pattern_left = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (stall_served != stall_requests)
            begin
                stall_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern      = ready_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 300);
                end
                pattern_left--;
                case (pattern)
                    READY_ALWAYS:       out_ready <= 1'b1;
                    READY_MOSTLY:       out_ready <= ($urandom_range(0, 9) < 7);
                    READY_RARELY:       out_ready <= ($urandom_range(0, 9) < 2);
                    READY_EVERY_FOURTH: out_ready <= (pattern_left % 4 == 0);
                    default:            out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response(found, successor);
    end

    // Request stimulus and end of run
    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of the value range, including a negative one and the stored maximum
        send_write(1, VALUE_MIN);
        send_write(2, VALUE_MAX);
        send_write(3, 0);
        send_write(4, -1);
        send_write(5, 1);
        send_write(LAST_POS, 700);
        send_write(LAST_POS - 1, -700);
        // dropped writes: position zero and above the array
        send_write(0, 5);
        send_write(POS_TOP, 6);
        send_write(LAST_POS + 1, 7);
        send_query(1, 5, VALUE_MIN);
        send_query(0, 5, -1);
        send_query(1, 5, VALUE_MAX);
        send_query(2, 2, VALUE_MAX - 1);
        send_query(1, 1, VALUE_MIN);
        send_query(LAST_POS - 1, POS_TOP, -701);
        send_query(LAST_POS, LAST_POS, 699);
        send_query(5, 3, 0);
        send_query(LAST_POS + 1, POS_TOP, VALUE_MIN);
        send_query(0, 0, VALUE_MIN);
        send_query(3, 4, -2);
        send_query(2, 2, VALUE_MIN);
        next_low  = 6;
        next_high = LAST_POS - 2;

        run_random_phase(EARLY_ITEMS, 1'b0);
        drain_responses();

        run_random_phase(LATE_ITEMS, 1'b1);
        drain_responses();
        repeat (LAST_POS + 8) @(posedge clk);

        if (sb.errors == 0)
            $display("range_successor_query_core test passed");
        else
            $display("range_successor_query_core test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("range_successor_query_core test failed");
        $finish;
    end

endmodule
